// ===== src/ted_pkg.sv =====
// ted_pkg: shared types, codes and helpers for the text encoding detector
// no dependencies

package ted_pkg;

	localparam int unsigned CpWidth = 21;

	localparam logic [CpWidth-1:0] CpMax       = 21'h10FFFF;
	localparam logic [CpWidth-1:0] SurrogateLo = 21'h00D800;
	localparam logic [CpWidth-1:0] SurrogateHi = 21'h00DFFF;
	localparam logic [CpWidth-1:0] MinCp2      = 21'h000080;
	localparam logic [CpWidth-1:0] MinCp3      = 21'h000800;
	localparam logic [CpWidth-1:0] MinCp4      = 21'h010000;

	localparam logic [7:0] BomFF = 8'hFF;
	localparam logic [7:0] BomFE = 8'hFE;
	localparam logic [7:0] BomEF = 8'hEF;
	localparam logic [7:0] BomBB = 8'hBB;

	localparam logic [1:0] PosNone  = 2'd0;
	localparam logic [1:0] PosFirst = 2'd1;
	localparam logic [1:0] PosBoth  = 2'd2;

	localparam logic [2:0] SeqLen1 = 3'd1;
	localparam logic [2:0] SeqLen2 = 3'd2;
	localparam logic [2:0] SeqLen3 = 3'd3;
	localparam logic [2:0] SeqLen4 = 3'd4;

	typedef enum logic [2:0] {
		ENC_ANSI     = 3'd0,
		ENC_UTF16_LE = 3'd1,
		ENC_UTF16_BE = 3'd2,
		ENC_UTF8_BOM = 3'd3,
		ENC_UTF8     = 3'd4
	} enc_class_t;

	typedef struct packed {
		logic [1:0]         byte_position;
		logic [7:0]         first_header_byte;
		logic [7:0]         second_header_byte;
		logic [1:0]         bytes_still_expected;
		logic [2:0]         sequence_length;
		logic [CpWidth-1:0] partial_code_point;
		logic               error_seen;
		logic               checking_stopped;
	} ted_state_t;

	function automatic logic code_point_bad(input logic [CpWidth-1:0] cp,
		input logic [2:0] len);
		logic [CpWidth-1:0] lowest;
		lowest = (len == SeqLen2) ? MinCp2 : (len == SeqLen3) ? MinCp3 : MinCp4;
		return (cp > CpMax) || ((cp >= SurrogateLo) && (cp <= SurrogateHi)) || (cp < lowest);
	endfunction

endpackage

// ===== src/ted_if.sv =====
// ted_byte_if and ted_verdict_if: request channels of the encoding detector
// valid/ready handshake, no package dependency

interface ted_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_text;

	modport source(output valid, output data_byte, output byte_present,
		output end_of_text, input ready);
	modport sink(input valid, input data_byte, input byte_present,
		input end_of_text, output ready);
endinterface

interface ted_verdict_if;
	logic       valid;
	logic       ready;
	logic [2:0] encoding_class;
	logic       utf8_valid;

	modport source(output valid, output encoding_class, output utf8_valid, input ready);
	modport sink(input valid, input encoding_class, input utf8_valid, output ready);
endinterface

// ===== src/text_encoding_detector.sv =====
// text_encoding_detector: top level, input register, state and verdict register
// depends on ted_pkg, ted_if (ted_byte_if, ted_verdict_if) and ted_step
// verdict path: an end-of-text request passes the input register, then its verdict is held in the verdict register
// throughput: one byte request per cycle, held back only while a verdict waits
// reset: arst_n clears the text state and both valid flags at once

module text_encoding_detector
	import ted_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	ted_byte_if.sink             byte_in,
	ted_verdict_if.source        verdict_out
);

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       byte_present_s1;
	logic       end_of_text_s1;

	ted_state_t state_q;
	ted_state_t state_nxt;
	logic [2:0] class_nxt;
	logic       valid_nxt;

	logic       out_valid_q;
	logic [2:0] out_class_q;
	logic       out_utf8_valid_q;

	logic       go_s1;
	logic       in_take;

	assign go_s1   = valid_s1 && (!end_of_text_s1 || !out_valid_q || verdict_out.ready);
	assign byte_in.ready = !valid_s1 || go_s1;
	assign in_take = byte_in.valid && byte_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_byte_s1    <= byte_in.data_byte;
			byte_present_s1 <= byte_in.byte_present;
			end_of_text_s1  <= byte_in.end_of_text;
		end
	end

	ted_step u_step (
		.st             (state_q),
		.data_byte      (data_byte_s1),
		.byte_present   (byte_present_s1),
		.end_of_text    (end_of_text_s1),
		.nxt            (state_nxt),
		.encoding_class (class_nxt),
		.utf8_valid     (valid_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (go_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && end_of_text_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && end_of_text_s1) begin
			out_class_q      <= class_nxt;
			out_utf8_valid_q <= valid_nxt;
		end
	end

	assign verdict_out.valid          = out_valid_q;
	assign verdict_out.encoding_class = out_class_q;
	assign verdict_out.utf8_valid     = out_utf8_valid_q;

endmodule

// ===== src/ted_step.sv =====
// ted_step: next-state and verdict logic for one byte request
// depends on ted_pkg

module ted_step
	import ted_pkg::*;
(
	input  ted_state_t st,
	input  logic [7:0] data_byte,
	input  logic       byte_present,
	input  logic       end_of_text,
	output ted_state_t nxt,
	output logic [2:0] encoding_class,
	output logic       utf8_valid
);

	ted_state_t s;
	logic       valid;
	enc_class_t cls;

	always_comb begin
		s = st;
		if (byte_present) begin
			if (s.byte_position == PosNone) begin
				s.first_header_byte = data_byte;
				s.byte_position = PosFirst;
			end else if (s.byte_position == PosFirst) begin
				s.second_header_byte = data_byte;
				s.byte_position = PosBoth;
			end
			if (!s.checking_stopped && !s.error_seen) begin
				if (s.bytes_still_expected == 2'd0) begin
					// lead byte classes
					if (data_byte == 8'h00) begin
						s.checking_stopped = 1'b1;
					end else if (data_byte[7] == 1'b0) begin
						s.sequence_length = SeqLen1;
					end else if (data_byte[7:5] == 3'b110) begin
						s.partial_code_point = {16'd0, data_byte[4:0]};
						s.sequence_length = SeqLen2;
						s.bytes_still_expected = 2'd1;
					end else if (data_byte[7:4] == 4'b1110) begin
						s.partial_code_point = {17'd0, data_byte[3:0]};
						s.sequence_length = SeqLen3;
						s.bytes_still_expected = 2'd2;
					end else if (data_byte[7:3] == 5'b11110) begin
						s.partial_code_point = {18'd0, data_byte[2:0]};
						s.sequence_length = SeqLen4;
						s.bytes_still_expected = 2'd3;
					end else begin
						s.error_seen = 1'b1;
					end
				end else if (data_byte[7:6] != 2'b10) begin
					s.error_seen = 1'b1;
					s.bytes_still_expected = 2'd0;
				end else begin
					s.partial_code_point = {s.partial_code_point[CpWidth-7:0], data_byte[5:0]};
					s.bytes_still_expected = s.bytes_still_expected - 2'd1;
					if (s.bytes_still_expected == 2'd0
						&& code_point_bad(s.partial_code_point, s.sequence_length)) begin
						s.error_seen = 1'b1;
					end
				end
			end
		end

		// truncated sequence at end of text
		if (end_of_text && !s.checking_stopped && !s.error_seen
			&& s.bytes_still_expected != 2'd0) begin
			s.error_seen = 1'b1;
		end
		valid = !s.error_seen;

		if (s.byte_position == PosBoth && s.first_header_byte == BomFF
			&& s.second_header_byte == BomFE) begin
			cls = ENC_UTF16_LE;
		end else if (s.byte_position == PosBoth && s.first_header_byte == BomFE
			&& s.second_header_byte == BomFF) begin
			cls = ENC_UTF16_BE;
		end else if (s.byte_position == PosBoth && s.first_header_byte == BomEF
			&& s.second_header_byte == BomBB) begin
			cls = ENC_UTF8_BOM;
		end else if (valid) begin
			cls = ENC_UTF8;
		end else begin
			cls = ENC_ANSI;
		end

		nxt = end_of_text ? '0 : s;
		encoding_class = cls;
		utf8_valid = valid;
	end

endmodule

// ===== tb/text_encoding_detector_tb.sv =====
// text_encoding_detector_tb: byte-stream testbench for the text encoding detector
// drives ted_byte_if, checks ted_verdict_if against a cycle-free model of the verdict
// depends on ted_pkg, ted_if and text_encoding_detector
`timescale 1ns / 100ps

module text_encoding_detector_tb;
	import ted_pkg::*;

	localparam int CycleLimit = 100000;
	localparam int HoldCycles = 300;
	localparam int PhaseReqs  = 400;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       eot;
	} byte_req_t;

	typedef struct {
		enc_class_t cls;
		logic       ok;
	} verdict_t;

	class encoding_scoreboard;
		logic [1:0]         bytes_seen;
		logic [7:0]         head0;
		logic [7:0]         head1;
		logic [1:0]         cont_owed;
		logic [2:0]         seq_len;
		logic [CpWidth-1:0] code_point;
		bit                 utf8_broken;
		bit                 scan_halted;
		verdict_t           expected_verdicts[$];
		int                 failures;

		function new();
			failures = 0;
			restart();
		endfunction

		function void restart();
			bytes_seen  = PosNone;
			head0       = '0;
			head1       = '0;
			cont_owed   = '0;
			seq_len     = '0;
			code_point  = '0;
			utf8_broken = 1'b0;
			scan_halted = 1'b0;
		endfunction

		function bit illegal_cp(logic [CpWidth-1:0] cp, logic [2:0] len);
			logic [CpWidth-1:0] floor_cp;
			floor_cp = (len == SeqLen2) ? MinCp2 : (len == SeqLen3) ? MinCp3 : MinCp4;
			return (cp > CpMax) || (cp >= SurrogateLo && cp <= SurrogateHi) || (cp < floor_cp);
		endfunction

		function void scan_byte(logic [7:0] b);
			if (scan_halted || utf8_broken)
				return;
			if (cont_owed == 2'd0) begin
				if (b == 8'h00) begin
					scan_halted = 1'b1;
				end else if (!b[7]) begin
					seq_len = SeqLen1;
				end else if (b[7:5] == 3'b110) begin
					code_point = CpWidth'(b[4:0]);
					seq_len    = SeqLen2;
					cont_owed  = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					code_point = CpWidth'(b[3:0]);
					seq_len    = SeqLen3;
					cont_owed  = 2'd2;
				end else if (b[7:3] == 5'b11110) begin
					code_point = CpWidth'(b[2:0]);
					seq_len    = SeqLen4;
					cont_owed  = 2'd3;
				end else begin
					utf8_broken = 1'b1;
				end
				return;
			end
			if (b[7:6] != 2'b10) begin
				utf8_broken = 1'b1;
				cont_owed   = 2'd0;
				return;
			end
			code_point = {code_point[CpWidth-7:0], b[5:0]};
			cont_owed  = cont_owed - 2'd1;
			if (cont_owed == 2'd0 && illegal_cp(code_point, seq_len))
				utf8_broken = 1'b1;
		endfunction

		function void note_request(byte_req_t req);
			verdict_t v;
			if (req.present) begin
				if (bytes_seen == PosNone) begin
					head0      = req.data;
					bytes_seen = PosFirst;
				end else if (bytes_seen == PosFirst) begin
					head1      = req.data;
					bytes_seen = PosBoth;
				end
				scan_byte(req.data);
			end
			if (!req.eot)
				return;
			// a sequence still open at the end counts as broken
			if (!scan_halted && !utf8_broken && cont_owed != 2'd0)
				utf8_broken = 1'b1;
			v.ok = !utf8_broken;
			if (bytes_seen == PosBoth && head0 == BomFF && head1 == BomFE)
				v.cls = ENC_UTF16_LE;
			else if (bytes_seen == PosBoth && head0 == BomFE && head1 == BomFF)
				v.cls = ENC_UTF16_BE;
			else if (bytes_seen == PosBoth && head0 == BomEF && head1 == BomBB)
				v.cls = ENC_UTF8_BOM;
			else
				v.cls = v.ok ? ENC_UTF8 : ENC_ANSI;
			expected_verdicts.push_back(v);
			restart();
		endfunction

		function void check_verdict(logic [2:0] cls, logic ok);
			verdict_t v;
			if (expected_verdicts.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected verdict: class %0d valid %0b", cls, ok);
				return;
			end
			v = expected_verdicts.pop_front();
			if (cls !== v.cls || ok !== v.ok) begin
				failures++;
				if (failures <= 10)
					$display("verdict mismatch: expected class %0d valid %0b, got class %0d valid %0b",
						v.cls, v.ok, cls, ok);
			end
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ted_byte_if    byte_ch();
	ted_verdict_if verdict_ch();

	text_encoding_detector dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_ch),
		.verdict_out(verdict_ch)
	);

	encoding_scoreboard board = new();

	logic [7:0] text_bytes[$];
	byte_req_t  req_q[$];
	int         counted_reqs = 0;
	int         sink_stall = 0;
	bit         hold_go = 1'b0;
	bit         hold_active = 1'b0;
	int         cycle_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_cnt < CycleLimit) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("text_encoding_detector_tb: done, errors");
		$finish;
	end

	// long receiver hold-off
	initial begin
		forever begin
			wait (hold_go);
			hold_active = 1'b1;
			repeat (HoldCycles) @(posedge clk);
			hold_active = 1'b0;
			hold_go     = 1'b0;
		end
	end

	initial begin
		verdict_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_active)
				verdict_ch.ready <= 1'b0;
			else
				verdict_ch.ready <= ($urandom_range(99) >= sink_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && verdict_ch.valid && verdict_ch.ready)
			board.check_verdict(verdict_ch.encoding_class, verdict_ch.utf8_valid);
	end

	function automatic void push_seq(logic [20:0] cp, logic [2:0] len);
		case (len)
		SeqLen1: text_bytes.push_back({1'b0, cp[6:0]});
		SeqLen2: begin
			text_bytes.push_back({3'b110, cp[10:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end
		SeqLen3: begin
			text_bytes.push_back({4'b1110, cp[15:12]});
			text_bytes.push_back({2'b10, cp[11:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end
		default: begin
			text_bytes.push_back({5'b11110, cp[20:18]});
			text_bytes.push_back({2'b10, cp[17:12]});
			text_bytes.push_back({2'b10, cp[11:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end
		endcase
	endfunction

	function automatic logic [20:0] legal_cp(logic [2:0] len);
		logic [20:0] cp;
		case (len)
		SeqLen1: cp = 21'($urandom_range(1, 127));
		SeqLen2: cp = 21'($urandom_range(MinCp2, MinCp3 - 1));
		SeqLen3: begin
			cp = 21'($urandom_range(MinCp3, MinCp4 - 1));
			if (cp >= SurrogateLo && cp <= SurrogateHi)
				cp = cp ^ 21'h002000;
		end
		default: cp = 21'($urandom_range(MinCp4, CpMax));
		endcase
		return cp;
	endfunction

	function automatic void push_good();
		int unsigned roll;
		logic [2:0]  len;
		roll = $urandom_range(5);
		len  = (roll < 3) ? SeqLen1 : 3'(roll - 1);
		push_seq(legal_cp(len), len);
	endfunction

	function automatic void push_defect();
		logic [2:0] len;
		len = 3'($urandom_range(2, 4));
		case ($urandom_range(10))
		0: push_seq(21'($urandom_range(0, MinCp2 - 1)), SeqLen2);
		1: push_seq(21'($urandom_range(0, MinCp3 - 1)), SeqLen3);
		2: push_seq(21'($urandom_range(0, MinCp4 - 1)), SeqLen4);
		3: push_seq(21'($urandom_range(SurrogateLo, SurrogateHi)), SeqLen3);
		4: push_seq(21'($urandom_range(CpMax + 1, 21'h1FFFFF)), SeqLen4);
		5: text_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
		6: text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
		7: begin
			push_seq(legal_cp(len), len);
			repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
		end
		8: begin
			push_seq(legal_cp(len), len);
			repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
			text_bytes.push_back(8'h00);
		end
		9: text_bytes.push_back(8'h00);
		default: text_bytes.push_back(8'($urandom_range(255)));
		endcase
	endfunction

	function automatic void queue_text(bit bare_end);
		int last;
		last = text_bytes.size() - 1;
		foreach (text_bytes[i]) begin
			if ($urandom_range(19) == 0)
				req_q.push_back('{8'($urandom_range(255)), 1'b0, 1'b0});
			req_q.push_back('{text_bytes[i], 1'b1, !bare_end && i == last});
			counted_reqs++;
		end
		if (bare_end || text_bytes.size() == 0) begin
			req_q.push_back('{8'($urandom_range(255)), 1'b0, 1'b1});
			counted_reqs++;
		end
	endfunction

	function automatic void make_text();
		int unsigned roll;
		int          nchars;
		int          bad_at;
		text_bytes.delete();
		roll = $urandom_range(99);
		if (roll < 10) begin
			repeat ($urandom_range(1, 8)) text_bytes.push_back(8'($urandom_range(255)));
		end else begin
			if (roll < 24) begin
				case ($urandom_range(3))
				0: text_bytes = '{BomFF, BomFE};
				1: text_bytes = '{BomFE, BomFF};
				2: text_bytes = '{BomEF, BomBB, 8'hBF};
				default: text_bytes = '{BomFF, BomFF};
				endcase
			end
			nchars = $urandom_range(0, 6);
			bad_at = ($urandom_range(99) < 35) ? $urandom_range(0, nchars) : -1;
			for (int i = 0; i < nchars; i++) begin
				if (i == bad_at)
					push_defect();
				else
					push_good();
			end
		end
		queue_text($urandom_range(2) == 0);
	endfunction

	task automatic send_req(byte_req_t req, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid        <= 1'b1;
		byte_ch.data_byte    <= req.data;
		byte_ch.byte_present <= req.present;
		byte_ch.end_of_text  <= req.eot;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		board.note_request(req);
		@(negedge clk);
	endtask

	task automatic send_all(int idle_pct);
		while (req_q.size() != 0)
			send_req(req_q.pop_front(), idle_pct);
		byte_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (board.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(int src_idle, int snk_idle);
		int start;
		start      = counted_reqs;
		sink_stall = snk_idle;
		while (counted_reqs - start < PhaseReqs)
			make_text();
		send_all(src_idle);
		drain();
	endtask

	initial begin
		arst_n               = 1'b0;
		byte_ch.valid        = 1'b0;
		byte_ch.data_byte    = '0;
		byte_ch.byte_present = 1'b0;
		byte_ch.end_of_text  = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty text, one-byte text, the three BOMs, max code point,
		// surrogate, overlong, null stop, truncation, null inside a sequence
		text_bytes.delete();
		queue_text(1'b1);
		text_bytes = '{8'h41};
		queue_text(1'b0);
		text_bytes = '{BomFF, BomFE};
		queue_text(1'b0);
		text_bytes = '{BomFE, BomFF};
		queue_text(1'b1);
		text_bytes = '{BomEF, BomBB, 8'hBF};
		queue_text(1'b0);
		req_q.push_back('{8'hA5, 1'b0, 1'b0});
		text_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
		queue_text(1'b0);
		text_bytes = '{8'hED, 8'hA0, 8'h80};
		queue_text(1'b0);
		text_bytes = '{8'hC0, 8'h80};
		queue_text(1'b0);
		text_bytes = '{8'h00, 8'hFF};
		queue_text(1'b0);
		text_bytes = '{8'hE2, 8'h82};
		queue_text(1'b0);
		text_bytes = '{8'hC2, 8'h00};
		queue_text(1'b0);
		send_all(0);
		drain();

		run_phase(0, 0);
		run_phase(66, 0);
		run_phase(0, 66);
		run_phase(11, 11);

		// receiver held off while requests keep coming
		sink_stall = 0;
		while (req_q.size() < 80)
			make_text();
		hold_go = 1'b1;
		send_all(0);
		drain();

		repeat (4) @(posedge clk);
		if (board.failures == 0)
			$display("text_encoding_detector_tb: done, clean");
		else
			$display("text_encoding_detector_tb: done, errors");
		$finish;
	end

endmodule
